FILE: rtl/modexp_pkg.sv
package modexp_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_EXPONENT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MODULUS  = CfgIdxW'(1);

  // Width of every operand port.
  localparam int unsigned PortW = 64;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } modexp_state_e;

endpackage

FILE: rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: r = (a * b) mod n, scanning b from its top bit.
// One bit of b per cycle; done_o pulses when r_o holds the product.
// Requires a <= n and n > 0; the partial remainder then always stays below 3n.
module modexp_mulmod #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;

  // Double, add the addend for the current bit, then take off 2n or n where the sum reaches it.
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] sub_one;
  logic [WIDTH+1:0] sub_two;
  logic [WIDTH-1:0] step_r;

  always_comb begin
    sum     = {1'b0, r_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
    sub_one = sum - {2'b00, n_i};
    sub_two = sum - {1'b0, n_i, 1'b0};
    if (!sub_two[WIDTH+1]) begin
      step_r = sub_two[WIDTH-1:0];
    end else if (!sub_one[WIDTH+1]) begin
      step_r = sub_one[WIDTH-1:0];
    end else begin
      step_r = sum[WIDTH-1:0];
    end
  end

  // Sequencing of the bit steps.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH - 1);
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      r_d = step_r;
      b_d = {b_q[WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// Modular exponentiation: power = base ^ exponent mod modulus by left-to-right
// square and multiply, one base per beat, one result beat per input beat. The
// exponent and modulus are configuration registers; the user must see that
// they are written only while idle, as the block itself does not enforce it.
// All work goes through one bit-serial modular multiplier: one pass reduces
// the base, then every exponent bit from bit WIDTH-1 down costs a squaring,
// plus a multiply when the bit is set. A zero modulus returns 0 with bad_modulus
// set, and a zero exponent returns 1.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PortW-1:0]   cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PortW-1:0]   base_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PortW-1:0]   power_o,
  output logic               bad_modulus_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  modexp_state_e state_q, state_d;

  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] exp_sh_q;
  logic [CntW-1:0]  bit_cnt_q;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] z_q;
  logic             bad_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] power_q;
  logic             out_bad_q;

  logic             in_fire;
  logic             quick;
  logic             last_bit;
  logic             next_bit;
  logic             out_load;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic             mm_done;
  logic [WIDTH-1:0] mm_r;
  logic [WIDTH-1:0] z_init;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= WIDTH'(65537);
      mod_q <= WIDTH'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXPONENT: exp_q <= cfg_data_i[WIDTH-1:0];
        CFG_MODULUS:  mod_q <= cfg_data_i[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Shared serial multiplier.
  modexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .n_i    (mod_q),
    .done_o (mm_done),
    .r_o    (mm_r)
  );

  // Decode helpers.
  assign in_fire  = in_valid_i && in_ready_o;
  assign quick    = (mod_q == '0) || (exp_q == '0);
  assign last_bit = (bit_cnt_q == '0);
  assign z_init   = (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign next_bit = mm_done && !last_bit &&
                    ((state_q == ST_SQUARE && !exp_sh_q[WIDTH-1]) ||
                     (state_q == ST_MULT));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = quick ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          if (exp_sh_q[WIDTH-1]) begin
            state_d = ST_MULT;
          end else if (last_bit) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MULT: begin
        if (mm_done) begin
          state_d = last_bit ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier launches and handshake controls.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mm_start   = 1'b0;
    mm_a       = mm_r;
    mm_b       = mm_r;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !quick) begin
          // Reduce the base: multiply it by one.
          mm_start = 1'b1;
          mm_a     = WIDTH'(1);
          mm_b     = base_i[WIDTH-1:0];
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          mm_start = 1'b1;
          mm_a     = z_init;
          mm_b     = z_init;
        end
      end
      ST_SQUARE: begin
        if (mm_done && exp_sh_q[WIDTH-1]) begin
          mm_start = 1'b1;
          mm_b     = x_q;
        end else if (next_bit) begin
          mm_start = 1'b1;
        end
      end
      ST_MULT: begin
        mm_start = next_bit;
      end
      ST_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        bit_cnt_q <= CntW'(WIDTH - 1);
      end else if (next_bit) begin
        bit_cnt_q <= bit_cnt_q - CntW'(1);
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      exp_sh_q <= exp_q;
      z_q      <= (mod_q == '0) ? '0 : WIDTH'(1);
      bad_q    <= (mod_q == '0);
    end else begin
      if (next_bit) begin
        exp_sh_q <= {exp_sh_q[WIDTH-2:0], 1'b0};
      end
      if (mm_done && (state_q == ST_SQUARE || state_q == ST_MULT)) begin
        z_q <= mm_r;
      end
    end
    if (mm_done && state_q == ST_REDUCE) begin
      x_q <= mm_r;
    end
    if (out_load) begin
      power_q   <= z_q;
      out_bad_q <= bad_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign power_o       = PortW'(power_q);
  assign bad_modulus_o = out_bad_q;

endmodule

FILE: rtl/modexp_checker.sv
// Port-level checks for the modular exponentiation block.
module modexp_checker
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PortW-1:0] power_o,
  input logic             bad_modulus_o
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(power_o) &&
    $stable(bad_modulus_o))
    else $error("result beat changed while stalled");

  // A result beat only leaves after it was taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result beat dropped");

  // A zero modulus always reports a zero power.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> power_o == '0)
    else $error("bad modulus with nonzero power");

  // The result never carries bits above the operand width.
  a_power_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (power_o >> WIDTH) == '0)
    else $error("power wider than operand width");

  // One item at a time: the input closes right after a beat is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

endmodule

bind modular_exponentiation modexp_checker #(
  .WIDTH(WIDTH)
) u_modexp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .power_o      (power_o),
  .bad_modulus_o(bad_modulus_o)
);
